// File: design/aupd_pkg.sv
// ----------------------------------------------------------------------------
// aupd_pkg: shared types and constants for the adaptor and USB plug detector
// Holds the plug state encoding, the register indexes and their reset
// values, and the word types passed between the modules.
// ----------------------------------------------------------------------------
package aupd_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_W     = 10;
  localparam int SUSP_W     = 16;

  // Register reset values.
  localparam logic [TICK_W-1:0] RST_INSERT_CONFIRM  = 10'd16;
  localparam logic [TICK_W-1:0] RST_INITIAL_TIMEOUT = 10'd24;
  localparam logic [TICK_W-1:0] RST_REMOVE_CONFIRM  = 10'd8;
  localparam logic [TICK_W-1:0] RST_REINSERT        = 10'd3;
  localparam logic [TICK_W-1:0] RST_USB_OUT         = 10'd3;
  localparam logic [SUSP_W-1:0] RST_PHY_SUSPEND     = 16'd100;

  // Plug state encoding, as reported on the result word.
  typedef enum logic [1:0] {
    ST_UNKNOWN  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_INIT_OUT = 2'd3
  } plug_state_t;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INSERT_CONFIRM  = 3'd0,
    CFG_INITIAL_TIMEOUT = 3'd1,
    CFG_REMOVE_CONFIRM  = 3'd2,
    CFG_REINSERT        = 3'd3,
    CFG_USB_OUT         = 3'd4,
    CFG_PHY_SUSPEND     = 3'd5
  } cfg_idx_t;

  // Register set handed from the register file to the core.
  typedef struct packed {
    logic [TICK_W-1:0] insert_confirm_ticks;
    logic [TICK_W-1:0] initial_timeout_ticks;
    logic [TICK_W-1:0] remove_confirm_ticks;
    logic [TICK_W-1:0] reinsert_ticks;
    logic [TICK_W-1:0] usb_out_ticks;
    logic [SUSP_W-1:0] phy_suspend_ticks;
  } cfg_t;

  // One poll tick.
  typedef struct packed {
    logic adaptor_level;
    logic usb_level;
    logic device_mode;
  } in_word_t;

  // One result.
  typedef struct packed {
    plug_state_t adaptor_state;
    logic        usb_init_pulse;
    logic        removed_pulse;
    logic        exit_clear_pulse;
    logic        disconnect_pulse;
    logic        suspend_pulse;
  } out_word_t;

endpackage

// File: design/aupd_in_if.sv
// ----------------------------------------------------------------------------
// aupd_in_if: poll tick channel
// Carries valid, ready and the sensed levels of one tick.
// ----------------------------------------------------------------------------
interface aupd_in_if;
  logic valid;
  logic ready;
  logic adaptor_level;
  logic usb_level;
  logic device_mode;

  modport source (output valid, output adaptor_level, output usb_level,
                  output device_mode, input ready);
  modport sink (input valid, input adaptor_level, input usb_level,
                input device_mode, output ready);
endinterface

// File: design/aupd_out_if.sv
// ----------------------------------------------------------------------------
// aupd_out_if: result channel
// Carries valid, ready, the plug state and the event pulses of one tick.
// ----------------------------------------------------------------------------
interface aupd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] adaptor_state;
  logic       usb_init_pulse;
  logic       removed_pulse;
  logic       exit_clear_pulse;
  logic       disconnect_pulse;
  logic       suspend_pulse;

  modport source (output valid, output adaptor_state, output usb_init_pulse,
                  output removed_pulse, output exit_clear_pulse,
                  output disconnect_pulse, output suspend_pulse, input ready);
  modport sink (input valid, input adaptor_state, input usb_init_pulse,
                input removed_pulse, input exit_clear_pulse,
                input disconnect_pulse, input suspend_pulse, output ready);
endinterface

// File: design/aupd_cfg.sv
// ----------------------------------------------------------------------------
// aupd_cfg: configuration register file
// Six threshold registers written through a plain write port.
// ----------------------------------------------------------------------------
module aupd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [aupd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aupd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output aupd_pkg::cfg_t                   cfg
);
  import aupd_pkg::*;

  cfg_t cfg_r;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.insert_confirm_ticks  <= RST_INSERT_CONFIRM;
      cfg_r.initial_timeout_ticks <= RST_INITIAL_TIMEOUT;
      cfg_r.remove_confirm_ticks  <= RST_REMOVE_CONFIRM;
      cfg_r.reinsert_ticks        <= RST_REINSERT;
      cfg_r.usb_out_ticks         <= RST_USB_OUT;
      cfg_r.phy_suspend_ticks     <= RST_PHY_SUSPEND;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INSERT_CONFIRM:  cfg_r.insert_confirm_ticks  <= cfg_data[TICK_W-1:0];
        CFG_INITIAL_TIMEOUT: cfg_r.initial_timeout_ticks <= cfg_data[TICK_W-1:0];
        CFG_REMOVE_CONFIRM:  cfg_r.remove_confirm_ticks  <= cfg_data[TICK_W-1:0];
        CFG_REINSERT:        cfg_r.reinsert_ticks        <= cfg_data[TICK_W-1:0];
        CFG_USB_OUT:         cfg_r.usb_out_ticks         <= cfg_data[TICK_W-1:0];
        CFG_PHY_SUSPEND:     cfg_r.phy_suspend_ticks     <= cfg_data[SUSP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/aupd_core.sv
// ----------------------------------------------------------------------------
// aupd_core: plug state machine and tick counters
// Evaluates one poll tick against the stored state, updates the state and
// counters when stepped, and presents the result word for that tick.
// ----------------------------------------------------------------------------
module aupd_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  aupd_pkg::in_word_t  tick,
  input  aupd_pkg::cfg_t      cfg,
  output aupd_pkg::out_word_t res
);
  import aupd_pkg::*;

  // Comparisons are made at a width that holds both counters and thresholds.
  localparam int CMP_W = (COUNT_WIDTH > SUSP_W) ? COUNT_WIDTH : SUSP_W;

  plug_state_t            state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] high_r, high_nxt;
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [COUNT_WIDTH-1:0] usb_r, usb_nxt;
  logic [COUNT_WIDTH-1:0] idle_r, idle_nxt;
  logic                   susp_done_r, susp_done_nxt;

  logic [COUNT_WIDTH-1:0] high_inc, elapsed_inc, usb_inc, idle_inc;
  logic ins_hit, tmo_hit, rem_hit, rei_hit, iout_hit, disc_hit, susp_hit;
  logic idle_below;

  // Saturating increment: a counter stops at its all-ones value.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  assign high_inc    = sat_inc(high_r);
  assign elapsed_inc = sat_inc(elapsed_r);
  assign usb_inc     = sat_inc(usb_r);
  assign idle_inc    = sat_inc(idle_r);

  // Transition and event conditions for this tick.
  assign ins_hit  = (state_r == ST_UNKNOWN) && tick.adaptor_level &&
                    (CMP_W'(high_inc) > CMP_W'(cfg.insert_confirm_ticks));
  assign tmo_hit  = (state_r == ST_UNKNOWN) && !ins_hit &&
                    (CMP_W'(elapsed_inc) > CMP_W'(cfg.initial_timeout_ticks));
  assign rem_hit  = (state_r == ST_INSERTED) && !tick.adaptor_level &&
                    (CMP_W'(elapsed_inc) > CMP_W'(cfg.remove_confirm_ticks));
  assign rei_hit  = (state_r == ST_REMOVED) && tick.adaptor_level &&
                    (CMP_W'(high_inc) > CMP_W'(cfg.reinsert_ticks));
  assign iout_hit = (state_r == ST_INIT_OUT) && tick.adaptor_level &&
                    (CMP_W'(elapsed_inc) > CMP_W'(cfg.reinsert_ticks));
  assign disc_hit = tick.device_mode && !tick.usb_level &&
                    (CMP_W'(usb_inc) > CMP_W'(cfg.usb_out_ticks));
  assign susp_hit = !tick.device_mode && tick.usb_level && !susp_done_r &&
                    (CMP_W'(idle_r) == CMP_W'(cfg.phy_suspend_ticks));
  assign idle_below = CMP_W'(idle_r) < CMP_W'(cfg.phy_suspend_ticks);

  // Next state and adaptor counters.
  always_comb begin
    state_nxt   = state_r;
    high_nxt    = high_r;
    elapsed_nxt = elapsed_inc;
    case (state_r)
      ST_UNKNOWN: begin
        high_nxt = tick.adaptor_level ? high_inc : '0;
        if (ins_hit) begin
          state_nxt   = ST_INSERTED;
          high_nxt    = '0;
          elapsed_nxt = '0;
        end else if (tmo_hit) begin
          state_nxt   = ST_INIT_OUT;
          elapsed_nxt = '0;
        end
      end
      ST_INSERTED: begin
        if (tick.adaptor_level) begin
          elapsed_nxt = '0;
        end else if (rem_hit) begin
          state_nxt = ST_REMOVED;
        end
      end
      ST_REMOVED: begin
        high_nxt = tick.adaptor_level ? high_inc : '0;
        if (rei_hit) begin
          state_nxt   = ST_INSERTED;
          elapsed_nxt = '0;
        end
      end
      ST_INIT_OUT: begin
        if (!tick.adaptor_level || iout_hit) begin
          elapsed_nxt = '0;
        end
        if (iout_hit) begin
          state_nxt = ST_INSERTED;
        end
      end
      default: begin
        state_nxt = ST_UNKNOWN;
      end
    endcase
  end

  // USB unplug and idle counters.
  always_comb begin
    usb_nxt       = usb_r;
    idle_nxt      = idle_r;
    susp_done_nxt = susp_done_r;
    if (tick.device_mode) begin
      if (tick.usb_level || disc_hit) begin
        usb_nxt = '0;
      end else begin
        usb_nxt = usb_inc;
      end
    end else if (tick.usb_level) begin
      if (susp_hit) begin
        susp_done_nxt = 1'b1;
      end else if (!susp_done_r && idle_below) begin
        idle_nxt = idle_inc;
      end
    end else begin
      idle_nxt      = '0;
      susp_done_nxt = 1'b0;
    end
  end

  // Result word for this tick.
  always_comb begin
    res.adaptor_state    = state_nxt;
    res.usb_init_pulse   = ins_hit || rei_hit || iout_hit;
    res.removed_pulse    = rem_hit;
    res.exit_clear_pulse = rei_hit;
    res.disconnect_pulse = disc_hit;
    res.suspend_pulse    = susp_hit;
  end

  // State and counter registers, advanced once per stepped tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_UNKNOWN;
      high_r      <= '0;
      elapsed_r   <= '0;
      usb_r       <= '0;
      idle_r      <= '0;
      susp_done_r <= 1'b0;
    end else if (step_en) begin
      state_r     <= state_nxt;
      high_r      <= high_nxt;
      elapsed_r   <= elapsed_nxt;
      usb_r       <= usb_nxt;
      idle_r      <= idle_nxt;
      susp_done_r <= susp_done_nxt;
    end
  end

  // The state only moves on a stepped tick.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(state_r))
    else $error("plug state changed without a tick");

  // A suspend request is followed by the done flag being set.
  a_susp_once: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && susp_hit) |=> susp_done_r)
    else $error("suspend done flag not set after suspend request");

  // The idle run never passes the suspend threshold.
  a_idle_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !susp_done_r && idle_below) |=> CMP_W'(idle_r) <= CMP_W'(cfg.phy_suspend_ticks))
    else $error("idle run passed the suspend threshold");

endmodule

// File: design/adaptor_usb_plug_detector_top.sv
// ----------------------------------------------------------------------------
// adaptor_usb_plug_detector_top: adaptor and USB plug detector
// Path: a tick accepted into the input register is evaluated by the core
// when stepped, and its result word is captured in the result register.
// Throughput: one tick per clock while the result channel does not stall,
// set by the state update between the input register and the result register.
// Reset: synchronous active-low rst_n clears the channel valids, the plug
// state and all counters, and loads the threshold registers' defaults.
// ----------------------------------------------------------------------------
module adaptor_usb_plug_detector_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  aupd_in_if.sink                          in_chan,
  aupd_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [aupd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aupd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import aupd_pkg::*;

  cfg_t      cfg;
  in_word_t  in_q_r;
  logic      in_v_r;
  out_word_t res;
  out_word_t out_q_r;
  logic      out_v_r;
  logic      out_take;
  logic      step_en;
  logic      in_acc;

  // Handshake: the input register drains whenever the result register is free.
  assign out_take       = !out_v_r || out_chan.ready;
  assign step_en        = in_v_r && out_take;
  assign in_chan.ready  = !in_v_r || out_take;
  assign in_acc         = in_chan.valid && in_chan.ready;

  aupd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aupd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .tick    (in_q_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Input register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (step_en) begin
      in_v_r <= 1'b0;
    end
  end

  // Input register: word.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_q_r.adaptor_level <= in_chan.adaptor_level;
      in_q_r.usb_level     <= in_chan.usb_level;
      in_q_r.device_mode   <= in_chan.device_mode;
    end
  end

  // Result register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_en) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  // Result register: word.
  always_ff @(posedge clk) begin
    if (step_en) begin
      out_q_r <= res;
    end
  end

  assign out_chan.valid            = out_v_r;
  assign out_chan.adaptor_state    = out_q_r.adaptor_state;
  assign out_chan.usb_init_pulse   = out_q_r.usb_init_pulse;
  assign out_chan.removed_pulse    = out_q_r.removed_pulse;
  assign out_chan.exit_clear_pulse = out_q_r.exit_clear_pulse;
  assign out_chan.disconnect_pulse = out_q_r.disconnect_pulse;
  assign out_chan.suspend_pulse    = out_q_r.suspend_pulse;

  // A removal word always reports the removed state.
  a_removed_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_q_r.removed_pulse) |-> (out_q_r.adaptor_state == ST_REMOVED))
    else $error("removed pulse without removed state");

  // Clearing the exit flag comes with a USB init request and the inserted state.
  a_clear_init: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_q_r.exit_clear_pulse) |->
      (out_q_r.usb_init_pulse && out_q_r.adaptor_state == ST_INSERTED))
    else $error("exit clear pulse without init request");

  // A held tick is not lost while the result register is stalled.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !step_en) |=> in_v_r)
    else $error("pending tick dropped");

endmodule
